### design/rcf_pkg.sv
package rcf_pkg;

   // Memory geometry and field widths
   localparam int WORD_W    = 32;
   localparam int MEM_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int CNT_W     = 11;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(MEM_DEPTH);
   localparam logic [CNT_W-1:0] HALF_CNT  = CNT_W'(MEM_DEPTH / 2);
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(8);
   localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(1);

   typedef enum logic [0:0] {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } rcf_cmd_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } rcf_status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } rcf_state_type;

   typedef struct packed {
      rcf_cmd_type               command;
      logic signed [WORD_W-1:0]  push_value;
   } rcf_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  pop_value;
      rcf_status_type            status;
      logic [CNT_W-1:0]          fill_count;
      logic [CNT_W-1:0]          capacity_now;
   } rcf_rsp_type;

   typedef struct packed {
      logic                      wr_en;
      logic [ADDR_W-1:0]         wr_addr;
      logic [WORD_W-1:0]         wr_data;
      logic                      rd_en;
      logic [ADDR_W-1:0]         rd_addr;
   } rcf_mem_req_type;

endpackage

### design/rcf_mem.sv
module rcf_mem (
   input  logic                          clock,
   input  rcf_pkg::rcf_mem_req_type      mem_req,
   output logic [rcf_pkg::WORD_W-1:0]    rd_data
);
   import rcf_pkg::*;

   logic [WORD_W-1:0] entry_mem [MEM_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= entry_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rcf_ctrl.sv
module rcf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rcf_pkg::CNT_W-1:0]     csr_wr_data,
   input  logic                          item_valid,
   input  rcf_pkg::rcf_req_type          item,
   output rcf_pkg::rcf_mem_req_type      mem_req,
   input  logic [rcf_pkg::WORD_W-1:0]    mem_rd_data,
   output logic                          busy,
   output logic                          res_valid,
   output rcf_pkg::rcf_rsp_type          res_data
);
   import rcf_pkg::*;

   rcf_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [ADDR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;
   logic [CNT_W-1:0]    clamped_cap;

   // Register write value limited to 1..depth
   always_comb begin
      if (csr_wr_data == '0) begin
         clamped_cap = CAP_MIN;
      end else if (csr_wr_data > DEPTH_CNT) begin
         clamped_cap = DEPTH_CNT;
      end else begin
         clamped_cap = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         cap_ff      <= CAP_RESET;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         cap_ff      <= cap_in;
      end
   end

   // The words sit in a ring over the whole memory, so a resize only
   // changes the capacity bookkeeping; the oldest word is always at head.
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      cap_in      = cap_ff;
      mem_req     = '0;
      res_valid   = 1'b0;
      res_data    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.command == CMD_PUSH) begin
                  if (count_ff >= cap_ff) begin
                     res_data.status = STS_FULL;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = tail_ff;
                     mem_req.wr_data = item.push_value;
                     tail_in         = tail_ff + 1'b1;
                     count_in        = count_ff + 1'b1;
                     // grow when full and the double still fits
                     if ((count_in == cap_ff) && (cap_ff <= HALF_CNT)) begin
                        cap_in = {cap_ff[CNT_W-2:0], 1'b0};
                     end
                     res_data.status = STS_DONE;
                  end
                  res_valid             = 1'b1;
                  res_data.fill_count   = count_in;
                  res_data.capacity_now = cap_in;
               end else begin
                  if (count_ff == '0) begin
                     res_valid             = 1'b1;
                     res_data.status       = STS_EMPTY;
                     res_data.fill_count   = count_ff;
                     res_data.capacity_now = cap_ff;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                     head_in         = head_ff + 1'b1;
                     count_in        = count_ff - 1'b1;
                     // shrink at a quarter full
                     if ((cap_ff > CAP_MIN) && (count_in <= (cap_ff >> 2))) begin
                        cap_in = cap_ff >> 1;
                     end
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            // read data of the pop is back
            res_valid             = 1'b1;
            res_data.pop_value    = mem_rd_data;
            res_data.status       = STS_DONE;
            res_data.fill_count   = count_ff;
            res_data.capacity_now = cap_ff;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write restarts the queue
      if (csr_wr_en) begin
         cap_in      = clamped_cap;
         count_in    = '0;
         head_in     = '0;
         tail_in     = '0;
      end
   end

   assign busy = (state_ff == ST_READ);

endmodule

### design/resizing_circular_fifo_core.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  rcf_req_type (command, push_value)
// rsp_      out        rsp_valid/rsp_stall  rcf_rsp_type (pop_value, status,
//                                           fill_count, capacity_now)
// csr_      in         csr_wr_en            csr_wr_data (initial_capacity)
//
// A push, a rejected push or an empty pop has its result registered into the result
// buffer; a pop that returns a word first passes through the memory read and ST_READ.
// The next item can be taken after a push or an empty pop; a pop that returns a
// word holds req_stall (busy) while the controller is in ST_READ.
// Synchronous reset: empty queue, capacity 8; memory content is not cleared.
// A two-entry result buffer lets input continue while one result is stalled.
module resizing_circular_fifo_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rcf_pkg::rcf_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rcf_pkg::rcf_rsp_type          rsp_data,
   input  logic                          csr_wr_en,
   input  logic [rcf_pkg::CNT_W-1:0]     csr_wr_data
);
   import rcf_pkg::*;

   rcf_mem_req_type   mem_req;
   logic [WORD_W-1:0] mem_rd_data;
   logic              busy;
   logic              res_valid;
   rcf_rsp_type       res_data;
   logic              item_valid;
   logic              take;

   rcf_rsp_type       slot0_ff, slot0_in;
   rcf_rsp_type       slot1_ff, slot1_in;
   logic [1:0]        occ_ff, occ_in;

   assign item_valid = req_valid & ~req_stall;
   assign req_stall  = busy | ((occ_ff == 2'd2) & rsp_stall);

   rcf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (req_data),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .busy        (busy),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   rcf_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // Two-entry result buffer, slot0 drives the output
   assign rsp_valid = (occ_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign take      = rsp_valid & ~rsp_stall;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      occ_in   = occ_ff + {1'b0, res_valid} - {1'b0, take};
      if (take) begin
         if (occ_ff == 2'd2) begin
            slot0_in = slot1_ff;
         end else begin
            slot0_in = res_data;
         end
      end else if (occ_ff == 2'd0) begin
         slot0_in = res_data;
      end
      if (res_valid && (((occ_ff == 2'd1) && !take) || ((occ_ff == 2'd2) && take))) begin
         slot1_in = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTH
   // a result never finds the buffer full
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !((occ_ff == 2'd2) && !take))
      else $error("result buffer overrun");

   // fill level never exceeds capacity
   a_fill_le_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fill_count <= rsp_data.capacity_now))
      else $error("fill count above capacity");

   // empty status only with an empty queue
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STS_EMPTY)) |-> (rsp_data.fill_count == '0))
      else $error("empty status with entries held");

   // a pop read is always followed by its result
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |=> res_valid)
      else $error("pop read without result");
`endif

endmodule

### bench/tb_top.sv
module tb_top;
   import rcf_pkg::*;

   localparam int RUN_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES = 4 * MEM_DEPTH;
   localparam int HOLD_CYCLES   = 64;
   localparam int WAVE_BUDGET   = 24;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   rcf_req_type          req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rcf_rsp_type          rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]     csr_wr_data = '0;

   // Shadow of the queue: words oldest first, plus the logical capacity
   logic signed [WORD_W-1:0] held_words[$];
   logic [CNT_W-1:0]         cap_now = CAP_RESET;
   rcf_rsp_type              pending_rsp[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  sender_quiet   = 1'b0;
   bit  rsp_quiet      = 1'b0;
   bit  rsp_hold       = 1'b0;
   int  stall_left     = 0;

   resizing_circular_fifo_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Next state of the queue for one transaction, and the result it gives
   function automatic rcf_rsp_type fifo_outcome(input rcf_req_type item);
      rcf_rsp_type r;
      r        = '0;
      r.status = STS_DONE;
      if (item.command == CMD_PUSH) begin
         if (held_words.size() >= cap_now) begin
            r.status = STS_FULL;
         end else begin
            held_words.push_back(item.push_value);
            // grow only while the doubled capacity fits the memory
            if (held_words.size() == cap_now && cap_now <= HALF_CNT) begin
               cap_now = cap_now << 1;
            end
         end
      end else if (held_words.size() == 0) begin
         r.status = STS_EMPTY;
      end else begin
         r.pop_value = held_words.pop_front();
         if (cap_now > CAP_MIN && held_words.size() <= cap_now / 4) begin
            cap_now = cap_now >> 1;
         end
      end
      r.fill_count   = CNT_W'(held_words.size());
      r.capacity_now = cap_now;
      return r;
   endfunction

   // Result sink: random stall per transaction, or a long hold-off on request
   initial begin : rsp_sink
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold   = 1'b0;
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else begin
            if (rsp_valid && !rsp_stall) begin
               stall_left = rsp_quiet ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      rcf_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result transaction with nothing pending");
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.pop_value !== want.pop_value) begin
               $error("pop_value: expected %0d, got %0d", want.pop_value,
                      rsp_data.pop_value);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, got %0d", want.fill_count,
                      rsp_data.fill_count);
               mismatch_count++;
            end
            if (rsp_data.capacity_now !== want.capacity_now) begin
               $error("capacity_now: expected %0d, got %0d", want.capacity_now,
                      rsp_data.capacity_now);
               mismatch_count++;
            end
         end
      end
   end

   // Offer one transaction; valid stays high so back-to-back items need no gap
   task automatic send_item(input rcf_cmd_type cmd, input logic [WORD_W-1:0] word);
      rcf_req_type item;
      int          gap;
      item.command    = cmd;
      item.push_value = word;
      gap = sender_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(fifo_outcome(item));
   endtask

   task automatic send_random(input int push_pct);
      if ($urandom_range(0, 99) < push_pct) begin
         send_item(CMD_PUSH, $urandom());
      end else begin
         send_item(CMD_POP, $urandom());
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // Capacity write, only once idle; the write restarts the queue, so the shadow empties too
   task automatic write_capacity(input logic [CNT_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      held_words.delete();
      if (value < CAP_MIN) begin
         cap_now = CAP_MIN;
      end else if (value > DEPTH_CNT) begin
         cap_now = DEPTH_CNT;
      end else begin
         cap_now = value;
      end
   endtask

   // Empty pop, word extremes, growth and shrink, clamped capacities
   task automatic test_directed();
      logic [WORD_W-1:0] words[8];
      words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE};
      send_item(CMD_POP, 32'h0);
      foreach (words[i]) send_item(CMD_PUSH, words[i]);
      foreach (words[i]) send_item(CMD_POP, ~words[i]);
      // zero clamps up to one: grows 1 -> 2 -> 4, shrinks back to 1
      write_capacity('0);
      send_item(CMD_PUSH, 32'h1234_5678);
      send_item(CMD_PUSH, 32'h8765_4321);
      send_item(CMD_POP, 32'h0);
      send_item(CMD_POP, 32'h0);
      // all ones clamps down to the memory depth
      write_capacity('1);
      send_item(CMD_PUSH, 32'hDEAD_BEEF);
      send_item(CMD_POP, 32'h0);
   endtask

   // Receiver holds off while the sender keeps offering, then sender pauses
   task automatic test_backpressure();
      sender_quiet = 1'b1;
      rsp_hold     = 1'b1;
      for (int i = 0; i < 16; i++) begin
         send_random(i < 10 ? 100 : 0);
      end
      wait_drained();
      sender_quiet = 1'b0;
      for (int i = 0; i < 8; i++) begin
         send_random(50);
      end
   endtask

   // Fill a capacity that cannot double, push into the full queue, then
   // free a few entries; the next capacity write restarts the queue
   task automatic test_full_at_max();
      write_capacity(CNT_W'(513));
      for (int i = 0; i < 513; i++) begin
         send_item(CMD_PUSH, $urandom());
      end
      for (int i = 0; i < 3; i++) begin
         send_item(CMD_PUSH, $urandom());
      end
      for (int i = 0; i < 4; i++) begin
         send_item(CMD_POP, $urandom());
      end
      send_item(CMD_PUSH, $urandom());
   endtask

   // Fill and drain waves of random depth under several capacity settings
   task automatic test_random_waves();
      logic [CNT_W-1:0] settings[6];
      int               target;
      int               sent;
      settings = '{CAP_RESET, CAP_MIN, CNT_W'(3), CNT_W'($urandom_range(1, 64)),
                   DEPTH_CNT, CNT_W'($urandom())};
      foreach (settings[s]) begin
         write_capacity(settings[s]);
         sent = 0;
         while (sent < WAVE_BUDGET) begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet    = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
               target = $urandom_range(30, 80);
            end else begin
               target = $urandom_range(1, 24);
            end
            while (held_words.size() < target) begin
               send_random(85);
               sent++;
            end
            while (held_words.size() > 0) begin
               send_random(15);
               sent++;
            end
         end
      end
      sender_quiet = 1'b0;
      rsp_quiet    = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_full_at_max();
      test_random_waves();
      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
